/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; sampled on i_clk, quiet while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check
`define BCP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that follows in the cycle after a trigger
`define BCP_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

/* hw/rtl/bcp_pkg.sv */
package bcp_pkg;

    localparam int NUM_KINDS = 6;
    localparam int CNT_W     = 17;
    localparam int PROB_W    = 17;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STATS_LIMIT = 2'd2;

    localparam logic [8:0]  DIST_LIMIT_RST  = 9'd256;
    localparam logic [4:0]  STACK_LIMIT_RST = 5'd16;
    localparam logic [15:0] STATS_LIMIT_RST = 16'd65535;

    localparam logic [CNT_W-1:0] HIT_RST   = 17'd1;
    localparam logic [CNT_W-1:0] TOTAL_RST = 17'd256;

    typedef logic [2:0] t_kind;

    typedef struct packed {
        logic accept;
        logic push;
        logic rd_upd;
        logic wr_upd;
        logic rd_pred;
        logic res_zero;
        logic div_load;
        logic div_step;
        logic out_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic push_path;
        logic nopred_path;
        logic has_pred;
        logic div_last;
        logic clr_last;
        logic out_free;
    } t_status;

    function automatic logic [7:0] closer_of(input t_kind k);
        logic [7:0] c;
        case (k)
            3'd0:    c = 8'h29;
            3'd1:    c = 8'h7D;
            3'd2:    c = 8'h5D;
            3'd3:    c = 8'h3E;
            3'd4:    c = 8'h27;
            3'd5:    c = 8'h22;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

    // {valid, kind}
    function automatic logic [3:0] opener_kind(input logic [7:0] b);
        logic [3:0] r;
        case (b)
            8'h28:   r = {1'b1, 3'd0};
            8'h7B:   r = {1'b1, 3'd1};
            8'h5B:   r = {1'b1, 3'd2};
            8'h3C:   r = {1'b1, 3'd3};
            8'h27:   r = {1'b1, 3'd4};
            8'h22:   r = {1'b1, 3'd5};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/bcp_ram.sv */
module bcp_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bcp_ctrl.sv */
`include "assert_macros.svh"

module bcp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bcp_pkg::t_status i_status,
    output bcp_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DECIDE   = 9'b000000100,
        S_RD_UPD   = 9'b000001000,
        S_MOD      = 9'b000010000,
        S_RD_PRED  = 9'b000100000,
        S_LOAD_DIV = 9'b001000000,
        S_DIV      = 9'b010000000,
        S_OUT      = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.nopred_path) begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_OUT;
                end else if (i_status.push_path) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_RD_PRED;
                end else begin
                    n_state = S_RD_UPD;
                end
            end
            S_RD_UPD: begin
                o_cmd.rd_upd = 1'b1;
                n_state      = S_MOD;
            end
            S_MOD: begin
                o_cmd.wr_upd = 1'b1;
                n_state      = S_RD_PRED;
            end
            S_RD_PRED: begin
                if (i_status.has_pred) begin
                    o_cmd.rd_pred = 1'b1;
                    n_state       = S_LOAD_DIV;
                end else begin
                    o_cmd.res_zero = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_LOAD_DIV: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `BCP_ASSERT_NEXT(a_accept_decides, w_accept, r_state == S_DECIDE,
        "accepted item did not move to decode")
    `BCP_ASSERT_NEXT(a_div_ends, (r_state == S_DIV) && i_status.div_last,
        r_state == S_OUT, "divide did not hand over to output")

endmodule

/* hw/rtl/bcp_dp.sv */
`include "assert_macros.svh"

module bcp_dp #(
    parameter int STACK_DEPTH  = 16,
    parameter int MAX_DISTANCE = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [7:0]                       i_byte,
    input  logic                             i_cfg_we,
    input  logic [bcp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bcp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_m_ready,
    output logic                             o_m_valid,
    output logic                             o_m_has,
    output logic [7:0]                       o_m_byte,
    output logic [bcp_pkg::PROB_W-1:0]       o_m_prob,
    input  bcp_pkg::t_cmd                    i_cmd,
    output bcp_pkg::t_status                 o_status
);

    localparam int IW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int DW      = $clog2(MAX_DISTANCE);
    localparam int ENTRIES = bcp_pkg::NUM_KINDS * MAX_DISTANCE;
    localparam int AW      = $clog2(ENTRIES);
    localparam int LW      = 12;
    localparam int RW      = 2 * bcp_pkg::CNT_W;
    localparam int QW      = bcp_pkg::PROB_W;

    // configuration
    logic [8:0]  r_dist_limit;
    logic [4:0]  r_stack_limit;
    logic [15:0] r_stats_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_limit  <= bcp_pkg::DIST_LIMIT_RST;
            r_stack_limit <= bcp_pkg::STACK_LIMIT_RST;
            r_stats_limit <= bcp_pkg::STATS_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bcp_pkg::CFG_DIST_LIMIT:  r_dist_limit  <= i_cfg_data[8:0];
                bcp_pkg::CFG_STACK_LIMIT: r_stack_limit <= i_cfg_data[4:0];
                bcp_pkg::CFG_STATS_LIMIT: r_stats_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stack
    bcp_pkg::t_kind r_kind [STACK_DEPTH];
    logic [DW-1:0]  r_dist [STACK_DEPTH];
    logic [CW-1:0]  r_count;
    bcp_pkg::t_kind n_kind [STACK_DEPTH];
    logic [DW-1:0]  n_dist [STACK_DEPTH];
    logic [CW-1:0]  n_count;

    logic [7:0]     r_byte;
    bcp_pkg::t_kind r_k;
    logic           r_push;
    logic           r_nopred;

    logic [CW-1:0]  w_top_full;
    logic [IW-1:0]  w_top;
    bcp_pkg::t_kind w_top_kind;
    logic [DW-1:0]  w_top_dist;
    logic [3:0]     w_in_ok;
    logic           w_in_push;
    logic           w_in_nopred;

    assign w_top_full = r_count - CW'(1);
    assign w_top      = w_top_full[IW-1:0];
    assign w_top_kind = r_kind[w_top];
    assign w_top_dist = r_dist[w_top];
    assign w_in_ok    = bcp_pkg::opener_kind(i_byte);

    // a quote that matches the open quote on top closes it instead of opening
    assign w_in_push = w_in_ok[3] && ((r_count == '0) ||
        !((w_top_kind == w_in_ok[2:0]) && (bcp_pkg::closer_of(w_in_ok[2:0]) == i_byte)));
    assign w_in_nopred = (r_count == '0) && !w_in_ok[3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_byte;
            r_k    <= w_in_ok[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_push   <= 1'b0;
            r_nopred <= 1'b0;
        end else if (i_cmd.accept) begin
            r_push   <= w_in_push;
            r_nopred <= w_in_nopred;
        end
    end

    logic [7:0]    w_slim;
    logic          w_drop;
    logic [CW-1:0] w_cnt_a;
    logic [LW-1:0] w_dl;
    logic [LW-1:0] w_dlim;
    logic          w_closes;
    logic          w_pop;

    assign w_slim = (8'(r_stack_limit) > 8'(STACK_DEPTH)) ? 8'(STACK_DEPTH)
                                                          : 8'(r_stack_limit);
    assign w_drop  = ((8'(r_count) + 8'd1) > w_slim) && (r_count != '0);
    assign w_cnt_a = r_count - CW'(w_drop);

    assign w_dl   = LW'(r_dist_limit);
    assign w_dlim = (w_dl == '0) ? LW'(1) :
                    ((w_dl > LW'(MAX_DISTANCE)) ? LW'(MAX_DISTANCE) : w_dl);
    assign w_closes = (bcp_pkg::closer_of(w_top_kind) == r_byte);
    assign w_pop    = w_closes || (LW'(w_top_dist) >= (w_dlim - LW'(1)));

    always_comb begin
        n_kind  = r_kind;
        n_dist  = r_dist;
        n_count = r_count;
        if (i_cmd.push) begin
            if (w_slim == 8'd0) begin
                n_count = '0;
            end else begin
                // drop the oldest entry
                if (w_drop) begin
                    for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                        n_kind[i] = r_kind[i+1];
                        n_dist[i] = r_dist[i+1];
                    end
                end
                n_kind[w_cnt_a[IW-1:0]] = r_k;
                n_dist[w_cnt_a[IW-1:0]] = '0;
                n_count = w_cnt_a + CW'(1);
            end
        end else if (i_cmd.wr_upd) begin
            if (w_pop) begin
                n_count = w_top_full;
            end else begin
                n_dist[w_top] = w_top_dist + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_dist <= n_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // count table
    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] w_upd_slot;
    logic [AW-1:0] w_pred_slot;
    bcp_pkg::t_kind w_pred_kind;
    logic [DW-1:0] w_pred_dist;
    logic          w_has_pred;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [RW-1:0] w_wdata;
    logic [RW-1:0] w_q;

    assign w_pred_kind = r_push ? r_k : w_top_kind;
    assign w_pred_dist = r_push ? '0 : w_top_dist;
    assign w_has_pred  = r_push || (r_count != '0);
    assign w_upd_slot  = AW'(w_top_kind) * AW'(MAX_DISTANCE) + AW'(w_top_dist);
    assign w_pred_slot = AW'(w_pred_kind) * AW'(MAX_DISTANCE) + AW'(w_pred_dist);

    logic [bcp_pkg::CNT_W-1:0] w_q_hit;
    logic [bcp_pkg::CNT_W-1:0] w_q_tot;
    logic [bcp_pkg::CNT_W:0]   w_hit1;
    logic [bcp_pkg::CNT_W:0]   w_tot1;
    logic                      w_over;
    logic [bcp_pkg::CNT_W-1:0] w_hit_new;
    logic [bcp_pkg::CNT_W-1:0] w_tot_new;

    assign w_q_hit   = w_q[RW-1:bcp_pkg::CNT_W];
    assign w_q_tot   = w_q[bcp_pkg::CNT_W-1:0];
    assign w_tot1    = {1'b0, w_q_tot} + 18'd1;
    assign w_hit1    = {1'b0, w_q_hit} + 18'(w_closes);
    assign w_over    = w_tot1 > 18'(r_stats_limit);
    assign w_hit_new = w_over ? w_hit1[bcp_pkg::CNT_W:1] : w_hit1[bcp_pkg::CNT_W-1:0];
    assign w_tot_new = w_over ? w_tot1[bcp_pkg::CNT_W:1] : w_tot1[bcp_pkg::CNT_W-1:0];

    always_comb begin
        w_addr  = w_upd_slot;
        w_wdata = {w_hit_new, w_tot_new};
        if (i_cmd.clr_step) begin
            w_addr  = r_clr_addr;
            w_wdata = {bcp_pkg::HIT_RST, bcp_pkg::TOTAL_RST};
        end else if (i_cmd.rd_pred) begin
            w_addr = w_pred_slot;
        end
    end

    assign w_we = i_cmd.clr_step || i_cmd.wr_upd;

    bcp_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (i_cmd.rd_upd || i_cmd.rd_pred),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // result staging
    logic       r_res_has;
    logic [7:0] r_res_byte;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_has <= 1'b0;
        end else if (i_cmd.rd_pred) begin
            r_res_has  <= 1'b1;
            r_res_byte <= bcp_pkg::closer_of(w_pred_kind);
        end
    end

    // restoring divide: hit * 65536 / total, one quotient bit a cycle
    logic [bcp_pkg::CNT_W-1:0]     r_rem;
    logic [bcp_pkg::CNT_W-1:0]     r_dsr;
    logic [QW-1:0]                 r_low;
    logic [QW-1:0]                 r_quot;
    logic [bcp_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                          r_zero_tot;
    logic [bcp_pkg::CNT_W:0]       w_trial;
    logic                          w_ge;

    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_rem      <= {1'b0, w_q_hit[bcp_pkg::CNT_W-1:1]};
            r_low      <= {w_q_hit[0], 16'd0};
            r_dsr      <= w_q_tot;
            r_quot     <= '0;
            r_div_cnt  <= '0;
            r_zero_tot <= (w_q_tot == '0);
        end else if (i_cmd.div_step) begin
            r_rem     <= w_ge ? 17'(w_trial - {1'b0, r_dsr}) : w_trial[bcp_pkg::CNT_W-1:0];
            r_low     <= {r_low[QW-2:0], 1'b0};
            r_quot    <= {r_quot[QW-2:0], w_ge};
            r_div_cnt <= r_div_cnt + 5'd1;
        end
    end

    // output register
    logic          r_m_valid;
    logic          r_m_has;
    logic [7:0]    r_m_byte;
    logic [QW-1:0] r_m_prob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_has  <= r_res_has;
            r_m_byte <= r_res_has ? r_res_byte : 8'd0;
            r_m_prob <= (r_res_has && !r_zero_tot) ? r_quot : '0;
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_has   = r_m_has;
    assign o_m_byte  = r_m_byte;
    assign o_m_prob  = r_m_prob;

    assign o_status.push_path   = r_push;
    assign o_status.nopred_path = r_nopred;
    assign o_status.has_pred    = w_has_pred;
    assign o_status.div_last    = (r_div_cnt == bcp_pkg::DIV_LAST);
    assign o_status.clr_last    = (r_clr_addr == AW'(ENTRIES - 1));
    assign o_status.out_free    = !r_m_valid || i_m_ready;

    `BCP_ASSERT(a_count_bound, r_count <= CW'(STACK_DEPTH),
        "stack count beyond depth")
    `BCP_ASSERT(a_no_overwrite, !i_cmd.out_load || !r_m_valid || i_m_ready,
        "result overwritten before it was taken")
    `BCP_ASSERT_NEXT(a_rem_below, i_cmd.div_load, (r_dsr == '0) || (r_rem < r_dsr),
        "initial remainder not below divisor")

endmodule

/* hw/rtl/bracket_close_predictor_unit.sv */
// Bracket close predictor.
// Input stream s_*: one byte of the coded stream per item. Output stream m_*:
// one result per input item: tuser carries has_prediction, tdata carries the
// predicted closing byte and its probability in unsigned Q1.16.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data, by the user
// only while idle; the block does not enforce it. Index 0 distance limit,
// 1 stack limit, 2 count halving limit. An opener goes from decode to the
// prediction read, the divider load, the 17-step serial divide and the output;
// other bytes on a non-empty stack first read and write back the count table
// entry of the top of stack. A byte that pops the last open entry, or that
// finds the stack empty and opens nothing, skips the divide and gives no
// prediction. One item is in flight at a time; the next is taken in the cycle
// after the result is loaded. Reset: control state clears, registers take
// their reset values, and a clearing pass writes all 6*MAX_DISTANCE entries
// (1536 by default) of the count table; s_tready stays low until it is done.
// When the receiver stalls the result is held in the output register and the
// block takes one more item, stopping before its own result.
module bracket_close_predictor_unit #(
    parameter int STACK_DEPTH  = 16,
    parameter int MAX_DISTANCE = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] byte_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [7:0] predicted_byte, [24:8] prob_q16
    output logic                           m_tuser,   // [0] has_prediction
    input  logic                           i_cfg_we,
    input  logic [bcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bcp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bcp_pkg::t_cmd    w_cmd;
    bcp_pkg::t_status w_status;
    logic [7:0]                 w_byte;
    logic [bcp_pkg::PROB_W-1:0] w_prob;

    bcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bcp_dp #(
        .STACK_DEPTH  (STACK_DEPTH),
        .MAX_DISTANCE (MAX_DISTANCE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (s_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_ready  (m_tready),
        .o_m_valid  (m_tvalid),
        .o_m_has    (m_tuser),
        .o_m_byte   (w_byte),
        .o_m_prob   (w_prob),
        .i_cmd      (w_cmd),
        .o_status   (w_status)
    );

    assign m_tdata = {7'd0, w_prob, w_byte};

endmodule
